// ===== hdl/fru_pkg.sv =====
package fru_pkg;

    // area kind register codes
    localparam logic [1:0] AREA_CHASSIS = 2'd0;
    localparam logic [1:0] AREA_BOARD   = 2'd1;
    localparam logic [1:0] AREA_PRODUCT = 2'd2;

    // end of fields marker and the area position that holds the checksum
    localparam logic [7:0] END_MARK   = 8'hC1;
    localparam logic [2:0] CHECK_SLOT = 3'd7;

    typedef enum logic [2:0] {
        PH_PREFIX     = 3'd0,
        PH_NAMED_TL   = 3'd1,
        PH_NAMED_DATA = 3'd2,
        PH_SKIP       = 3'd3,
        PH_EXTRA_TL   = 3'd4,
        PH_EXTRA_DATA = 3'd5,
        PH_PAD        = 3'd6,
        PH_CHECK      = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        KIND_PREFIX   = 3'd0,
        KIND_NAMED_TL = 3'd1,
        KIND_NAMED    = 3'd2,
        KIND_EXTRA    = 3'd3,
        KIND_PAD      = 3'd4,
        KIND_CHECKSUM = 3'd5,
        KIND_SKIP     = 3'd6
    } kind_t;

    localparam logic [2:0] NO_FIELD = 3'd7;

    typedef struct packed {
        phase_t      phase;
        logic [2:0]  pos;
        logic [2:0]  prefix_count;
        logic [2:0]  named_idx;
        logic [5:0]  bytes_left;
        logic [7:0]  sum;
        logic [7:0]  cur_tl;
    } fru_state_t;

    localparam fru_state_t STATE_CLEAR = '{
        phase:        PH_PREFIX,
        pos:          3'd0,
        prefix_count: 3'd0,
        named_idx:    3'd0,
        bytes_left:   6'd0,
        sum:          8'd0,
        cur_tl:       8'd0
    };

    typedef struct packed {
        kind_t       byte_kind;
        logic [2:0]  prefix_index;
        logic [2:0]  field_number;
        logic [1:0]  field_type;
        logic [5:0]  field_length;
        logic [7:0]  field_data;
        logic [7:0]  running_sum;
        logic        area_done;
        logic        checksum_ok;
    } fru_result_t;

endpackage

// ===== hdl/fru_if.sv =====
// byte stream into the parser
interface fru_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  area_byte;
    logic        restart;

    modport source (output valid, output area_byte, output restart, input ready);
    modport sink   (input valid, input area_byte, input restart, output ready);
endinterface

// tagged byte stream out of the parser
interface fru_out_if;
    logic                valid;
    logic                ready;
    fru_pkg::kind_t      byte_kind;
    logic [2:0]          prefix_index;
    logic [2:0]          field_number;
    logic [1:0]          field_type;
    logic [5:0]          field_length;
    logic [7:0]          field_data;
    logic [7:0]          running_sum;
    logic                area_done;
    logic                checksum_ok;

    modport source (
        output valid, output byte_kind, output prefix_index, output field_number,
        output field_type, output field_length, output field_data,
        output running_sum, output area_done, output checksum_ok,
        input  ready
    );
    modport sink (
        input  valid, input byte_kind, input prefix_index, input field_number,
        input  field_type, input field_length, input field_data,
        input  running_sum, input area_done, input checksum_ok,
        output ready
    );
endinterface

// ===== hdl/fru_step.sv =====
module fru_step
(
    input  fru_pkg::fru_state_t  state,
    input  logic [1:0]           area_kind,
    input  logic [7:0]           area_byte,
    input  logic                 restart,
    output fru_pkg::fru_state_t  state_next,
    output fru_pkg::fru_result_t result
);

    // number of fixed prefix bytes for the area kind
    function automatic logic [3:0] prefix_len(input logic [1:0] k);
        priority if (k == fru_pkg::AREA_CHASSIS) return 4'd3;
        else if (k == fru_pkg::AREA_BOARD)       return 4'd6;
        else                                     return 4'd3;
    endfunction

    // number of named fields for the area kind
    function automatic logic [3:0] named_count(input logic [1:0] k);
        priority if (k == fru_pkg::AREA_CHASSIS) return 4'd2;
        else if (k == fru_pkg::AREA_BOARD)       return 4'd5;
        else                                     return 4'd7;
    endfunction

    // one byte of parsing: phase decode, field tracking and zero sum
    always_comb
    begin
        fru_pkg::fru_state_t cur;
        fru_pkg::fru_state_t nxt;
        fru_pkg::kind_t      kind;
        logic [2:0]          pidx;
        logic [2:0]          fnum;
        logic [7:0]          tl;
        logic                done;
        logic                counted;
        logic [2:0]          next_pos;
        logic [3:0]          idx_inc;
        logic                more_named;
        logic                required;
        logic [7:0]          sum_new;

        cur        = restart ? fru_pkg::STATE_CLEAR : state;
        nxt        = cur;
        kind       = fru_pkg::KIND_PREFIX;
        pidx       = 3'd0;
        fnum       = fru_pkg::NO_FIELD;
        tl         = 8'd0;
        done       = 1'b0;
        counted    = 1'b1;
        next_pos   = cur.pos + 3'd1;
        idx_inc    = {1'b0, cur.named_idx} + 4'd1;
        more_named = idx_inc < named_count(area_kind);
        required   = (area_kind == fru_pkg::AREA_CHASSIS) || more_named;

        unique case (cur.phase)
            fru_pkg::PH_PREFIX:
            begin
                kind = fru_pkg::KIND_PREFIX;
                pidx = cur.prefix_count;
                if (({1'b0, cur.prefix_count} + 4'd1) >= prefix_len(area_kind))
                begin
                    nxt.phase     = fru_pkg::PH_NAMED_TL;
                    nxt.named_idx = 3'd0;
                end
                else
                begin
                    nxt.prefix_count = cur.prefix_count + 3'd1;
                end
            end
            fru_pkg::PH_NAMED_TL:
            begin
                kind       = fru_pkg::KIND_NAMED_TL;
                fnum       = cur.named_idx;
                tl         = area_byte;
                nxt.cur_tl = area_byte;
                priority if (area_byte == fru_pkg::END_MARK)
                begin
                    nxt.phase = (next_pos == fru_pkg::CHECK_SLOT) ?
                                fru_pkg::PH_CHECK : fru_pkg::PH_PAD;
                end
                else if (area_byte[5:0] != 6'd0)
                begin
                    nxt.bytes_left = area_byte[5:0];
                    nxt.phase      = fru_pkg::PH_NAMED_DATA;
                end
                else if (required)
                begin
                    nxt.phase = fru_pkg::PH_SKIP;
                end
                else if (more_named)
                begin
                    nxt.named_idx = idx_inc[2:0];
                    nxt.phase     = fru_pkg::PH_NAMED_TL;
                end
                else
                begin
                    nxt.phase = fru_pkg::PH_EXTRA_TL;
                end
            end
            fru_pkg::PH_NAMED_DATA:
            begin
                kind = fru_pkg::KIND_NAMED;
                fnum = cur.named_idx;
                tl   = cur.cur_tl;
                if (cur.bytes_left <= 6'd1)
                begin
                    nxt.bytes_left = 6'd0;
                    if (more_named)
                    begin
                        nxt.named_idx = idx_inc[2:0];
                        nxt.phase     = fru_pkg::PH_NAMED_TL;
                    end
                    else
                    begin
                        nxt.phase = fru_pkg::PH_EXTRA_TL;
                    end
                end
                else
                begin
                    nxt.bytes_left = cur.bytes_left - 6'd1;
                end
            end
            fru_pkg::PH_SKIP:
            begin
                kind    = fru_pkg::KIND_SKIP;
                fnum    = cur.named_idx;
                tl      = cur.cur_tl;
                counted = 1'b0;
                if (more_named)
                begin
                    nxt.named_idx = idx_inc[2:0];
                    nxt.phase     = fru_pkg::PH_NAMED_TL;
                end
                else
                begin
                    nxt.phase = fru_pkg::PH_EXTRA_TL;
                end
            end
            fru_pkg::PH_EXTRA_TL:
            begin
                kind       = fru_pkg::KIND_EXTRA;
                tl         = area_byte;
                nxt.cur_tl = area_byte;
                priority if (area_byte == fru_pkg::END_MARK)
                begin
                    nxt.phase = (next_pos == fru_pkg::CHECK_SLOT) ?
                                fru_pkg::PH_CHECK : fru_pkg::PH_PAD;
                end
                else if (area_byte[5:0] != 6'd0)
                begin
                    nxt.bytes_left = area_byte[5:0];
                    nxt.phase      = fru_pkg::PH_EXTRA_DATA;
                end
            end
            fru_pkg::PH_EXTRA_DATA:
            begin
                kind = fru_pkg::KIND_EXTRA;
                tl   = cur.cur_tl;
                if (cur.bytes_left <= 6'd1)
                begin
                    nxt.bytes_left = 6'd0;
                    nxt.phase      = fru_pkg::PH_EXTRA_TL;
                end
                else
                begin
                    nxt.bytes_left = cur.bytes_left - 6'd1;
                end
            end
            fru_pkg::PH_PAD:
            begin
                kind = fru_pkg::KIND_PAD;
                if (next_pos == fru_pkg::CHECK_SLOT)
                begin
                    nxt.phase = fru_pkg::PH_CHECK;
                end
            end
            fru_pkg::PH_CHECK:
            begin
                kind = fru_pkg::KIND_CHECKSUM;
                done = 1'b1;
            end
        endcase

        // modulo 256 sum, skip bytes left out
        sum_new = counted ? (cur.sum + area_byte) : cur.sum;

        result.byte_kind    = kind;
        result.prefix_index = pidx;
        result.field_number = fnum;
        result.field_type   = tl[7:6];
        result.field_length = tl[5:0];
        result.field_data   = area_byte;
        result.running_sum  = sum_new;
        result.area_done    = done;
        result.checksum_ok  = done && (sum_new == 8'd0);

        // the checksum byte closes the area and the next byte starts a new one
        if (done)
        begin
            state_next = fru_pkg::STATE_CLEAR;
        end
        else
        begin
            nxt.sum    = sum_new;
            nxt.pos    = next_pos;
            state_next = nxt;
        end
    end

endmodule

// ===== hdl/fru_info_area_parser.sv =====
// a byte's result is registered and shows on the output in the cycle after the byte is accepted
// throughput: one byte per cycle while results are taken as they come
// a result left waiting for ready holds off the input until it is taken
// reset: parse state cleared to the first prefix byte, no result held,
// area kind set to board info area
module fru_info_area_parser
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             area_kind_we,
    input  logic [1:0]       area_kind_wdata,
    fru_in_if.sink           in_ch,
    fru_out_if.source        out_ch
);

    logic [1:0]            area_kind_reg;
    fru_pkg::fru_state_t   state_reg;
    fru_pkg::fru_state_t   state_next;
    fru_pkg::fru_result_t  result_reg;
    fru_pkg::fru_result_t  result_next;
    logic                  out_valid_reg;
    logic                  in_take;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_kind_reg <= fru_pkg::AREA_BOARD;
        end
        else if (area_kind_we)
        begin
            area_kind_reg <= area_kind_wdata;
        end
    end

    // per byte parsing logic
    fru_step u_step
    (
        .state      (state_reg),
        .area_kind  (area_kind_reg),
        .area_byte  (in_ch.area_byte),
        .restart    (in_ch.restart),
        .state_next (state_next),
        .result     (result_next)
    );

    // take a transaction whenever the result register is free or being emptied
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_take     = in_ch.valid && in_ch.ready;

    // parse state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fru_pkg::STATE_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            state_reg     <= state_next;
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            result_reg <= result_next;
        end
    end

    // output channel
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.byte_kind    = result_reg.byte_kind;
    assign out_ch.prefix_index = result_reg.prefix_index;
    assign out_ch.field_number = result_reg.field_number;
    assign out_ch.field_type   = result_reg.field_type;
    assign out_ch.field_length = result_reg.field_length;
    assign out_ch.field_data   = result_reg.field_data;
    assign out_ch.running_sum  = result_reg.running_sum;
    assign out_ch.area_done    = result_reg.area_done;
    assign out_ch.checksum_ok  = result_reg.checksum_ok;

    // checksum slot byte yields a finished area result
    a_check_done: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && !in_ch.restart && state_reg.phase == fru_pkg::PH_CHECK
        |=> out_ch.valid && out_ch.area_done)
        else $error("checksum byte did not close the area");

    // after the checksum the parser is back at the first prefix byte
    a_auto_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && !in_ch.restart && state_reg.phase == fru_pkg::PH_CHECK
        |=> state_reg.phase == fru_pkg::PH_PREFIX && state_reg.pos == 3'd0
            && state_reg.sum == 8'd0)
        else $error("state not cleared after checksum");

    // skip bytes leave the sum untouched
    a_skip_sum: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && !in_ch.restart && state_reg.phase == fru_pkg::PH_SKIP
        |=> out_ch.running_sum == $past(state_reg.sum)
            && out_ch.byte_kind == fru_pkg::KIND_SKIP)
        else $error("skip byte altered the running sum");

    // every other byte moves the area position on by one
    a_position: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && !in_ch.restart && state_reg.phase != fru_pkg::PH_CHECK
        |=> state_reg.pos == $past(state_reg.pos) + 3'd1)
        else $error("area position out of step");

endmodule
